@@ rtl/core/dia_pkg.sv @@
// Package for the dyadic integer ALU: widths, operation codes, cell payload type.
// No dependencies.
package dia_pkg;
  localparam int W = 32;
  localparam int CW = $clog2(W);
  localparam int STAGES = W;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_AND = 4'd1, OP_NAND = 4'd2, OP_OR = 4'd3,
    OP_NOR = 4'd4, OP_XOR = 4'd5, OP_DIV = 4'd6, OP_MUL = 4'd7,
    OP_SHL = 4'd8, OP_SHR = 4'd9, OP_SUB = 4'd10, OP_LAND = 4'd11,
    OP_LEQ = 4'd12, OP_LGT = 4'd13, OP_LLT = 4'd14, OP_LOR = 4'd15
  } op_t;

  typedef struct packed {
    logic         vld;
    logic         is_div;
    logic         err;
    logic [W-1:0] quo;   // quotient bits being built, or finished result
    logic [W-1:0] rem;   // partial remainder
    logic [W-1:0] dvd;   // dividend bits still to shift in
    logic [W-1:0] dvs;   // divisor
  } cell_t;
endpackage

@@ rtl/core/dia_front.sv @@
// Entry stage: decodes the op, computes non-divide results, loads the divide chain.
// Depends on dia_pkg.
module dia_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [3:0]                mode,
  input  logic [dia_pkg::W-1:0]     operand_a,
  input  logic [dia_pkg::W-1:0]     operand_b,
  output dia_pkg::cell_t            cell_o
);
  import dia_pkg::*;

  cell_t cell_r, cell_nxt;
  logic [W-1:0] prod;
  logic big;
  logic [W-1:0] ones;
  logic [W-1:0] res;

  assign prod = operand_a * operand_b;
  assign big  = |(operand_b >> CW);
  assign ones = {W{1'b1}};

  always_comb begin
    res = '0;
    unique case (op_t'(mode))
      OP_ADD:  res = operand_a + operand_b;
      OP_AND:  res = operand_a & operand_b;
      OP_NAND: res = ~(operand_a & operand_b);
      OP_OR:   res = operand_a | operand_b;
      OP_NOR:  res = ~(operand_a | operand_b);
      OP_XOR:  res = operand_a ^ operand_b;
      OP_DIV:  res = '0;
      OP_MUL:  res = prod;
      OP_SHL:  res = big ? '0 : operand_a << operand_b[CW-1:0];
      OP_SHR:  res = big ? '0 : operand_a >> operand_b[CW-1:0];
      OP_SUB:  res = operand_a - operand_b;
      OP_LAND: res = ((|operand_a) && (|operand_b)) ? ones : '0;
      OP_LEQ:  res = (operand_a == operand_b) ? ones : '0;
      OP_LGT:  res = (operand_a > operand_b) ? ones : '0;
      OP_LLT:  res = (operand_a < operand_b) ? ones : '0;
      OP_LOR:  res = ((|operand_a) || (|operand_b)) ? ones : '0;
      default: res = '0;
    endcase
    cell_nxt.vld    = in_vld;
    cell_nxt.is_div = (op_t'(mode) == OP_DIV) && (|operand_b);
    cell_nxt.err    = (op_t'(mode) == OP_DIV) && !(|operand_b);
    cell_nxt.quo    = res;
    cell_nxt.rem    = '0;
    cell_nxt.dvd    = operand_a;
    cell_nxt.dvs    = operand_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r.vld <= cell_nxt.vld;
    end
    if (en) begin
      cell_r.is_div <= cell_nxt.is_div;
      cell_r.err    <= cell_nxt.err;
      cell_r.quo    <= cell_nxt.quo;
      cell_r.rem    <= cell_nxt.rem;
      cell_r.dvd    <= cell_nxt.dvd;
      cell_r.dvs    <= cell_nxt.dvs;
    end
  end

  assign cell_o = cell_r;
endmodule

@@ rtl/core/dia_cell.sv @@
// One restoring-division cell: settles one quotient bit, passes the item on.
// Depends on dia_pkg.
module dia_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  dia_pkg::cell_t cell_i,
  output dia_pkg::cell_t cell_o
);
  import dia_pkg::*;

  cell_t cell_r, cell_nxt;
  logic [W:0] trial;
  logic [W:0] diff;

  assign trial = {cell_i.rem, cell_i.dvd[W-1]};
  assign diff  = trial - {1'b0, cell_i.dvs};

  always_comb begin
    cell_nxt = cell_i;
    if (cell_i.is_div) begin
      cell_nxt.dvd = cell_i.dvd << 1;
      if (!diff[W]) begin
        cell_nxt.rem = diff[W-1:0];
        cell_nxt.quo = {cell_i.quo[W-2:0], 1'b1};
      end else begin
        cell_nxt.rem = trial[W-1:0];
        cell_nxt.quo = {cell_i.quo[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r.vld <= cell_nxt.vld;
    end
    if (en) begin
      cell_r.is_div <= cell_nxt.is_div;
      cell_r.err    <= cell_nxt.err;
      cell_r.quo    <= cell_nxt.quo;
      cell_r.rem    <= cell_nxt.rem;
      cell_r.dvd    <= cell_nxt.dvd;
      cell_r.dvs    <= cell_nxt.dvs;
    end
  end

  assign cell_o = cell_r;
endmodule

@@ rtl/core/dyadic_integer_alu.sv @@
// Dyadic integer ALU top level: entry stage, a row of divide cells, output stage.
// Every operation passes through the entry register, the 32 cell registers and the output register.
// Throughput: one beat per cycle; the whole row advances together, stalling
// only when the output register holds a beat that is not taken.
// Each of the 32 cells settles one quotient bit of a divide.
// Reset (rst_n low, synchronous) empties all stages.
module dyadic_integer_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [3:0] mode, [35:4] operand_a, [67:36] operand_b, pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [31:0] result_value, [63:32] remainder_value,
                                  // [64] divide_error, pad
);
  import dia_pkg::*;

  cell_t chain [STAGES+1];
  logic en;
  logic out_vld_r;
  logic [2*W:0] out_r;

  assign en = !out_vld_r || out_tready;
  assign in_tready = en;

  dia_front u_front (
    .clk, .rst_n, .en,
    .in_vld(in_tvalid),
    .mode(in_tdata[3:0]),
    .operand_a(in_tdata[35:4]),
    .operand_b(in_tdata[67:36]),
    .cell_o(chain[0])
  );

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    dia_cell u_cell (.clk, .rst_n, .en, .cell_i(chain[i]), .cell_o(chain[i+1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= chain[STAGES].vld;
    end
    if (en) begin
      out_r <= {chain[STAGES].err,
                chain[STAGES].is_div ? chain[STAGES].rem : {W{1'b0}},
                chain[STAGES].quo};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_r};

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed under stall");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64] |-> out_tdata[63:0] == 64'd0)
    else $error("divide error with nonzero data");
  a_rem_div: assert property (@(posedge clk) disable iff (!rst_n)
    chain[STAGES].vld && !chain[STAGES].is_div |-> chain[STAGES].rem == '0)
    else $error("remainder nonzero outside divide");
endmodule
